// ===== design/dpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dpsm_pkg
// Shared types and constants of the drive power state machine: state and
// command codes, configuration indexes, beat payloads and status encoding.
// ----------------------------------------------------------------------------
package dpsm_pkg;

	// drive power states
	typedef enum logic [2:0] {
		ST_NOTREADY = 3'd0,
		ST_DISABLED = 3'd1,
		ST_READY    = 3'd2,
		ST_SWON     = 3'd3,
		ST_ENABLED  = 3'd4,
		ST_QSTOP    = 3'd5,
		ST_REACT    = 3'd6,
		ST_FAULT    = 3'd7
	} drv_state_t;

	// drive commands
	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_RESET  = 3'd1,
		CMD_DISV   = 3'd2,
		CMD_QSTOP  = 3'd3,
		CMD_SHUT   = 3'd4,
		CMD_ENABLE = 3'd5,
		CMD_SWON   = 3'd6
	} cmd_t;

	// step verdict codes
	localparam logic [1:0] STEP_ERROR = 2'd0;
	localparam logic [1:0] STEP_KEEP  = 2'd1;
	localparam logic [1:0] STEP_NEXT  = 2'd2;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_USE_CW    = 3'd0,
		CFG_SEQ_SW    = 3'd1,
		CFG_DLY_READY = 3'd2,
		CFG_DLY_SWON  = 3'd3,
		CFG_DLY_EN    = 3'd4
	} cfg_idx_t;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	// control word bits and masks
	localparam logic [15:0] CW_RESET_BIT  = 16'h0080;
	localparam logic [15:0] CW_VOLTAGE    = 16'h0002;
	localparam logic [15:0] CW_NO_QSTOP   = 16'h0004;
	localparam logic [15:0] CW_SWITCH_ON  = 16'h0001;
	localparam logic [15:0] CW_CMD_MASK   = 16'h000F;
	localparam logic [15:0] CW_CMD_SWON   = 16'h0007;
	localparam logic [15:0] CW_CMD_ENABLE = 16'h000F;
	localparam logic [15:0] SW_STATE_MASK = 16'h006F;

	// input beat
	typedef struct packed {
		logic [15:0] ctrl_word;
		logic [2:0]  host_command;
		logic [1:0]  step_result;
		logic        reaction_done;
		logic [31:0] tick_now;
		logic [15:0] status_extra;
	} in_item_t;

	// result beat
	typedef struct packed {
		logic [2:0]  drive_state;
		logic [15:0] stat_word;
		logic [2:0]  active_command;
		logic        reset_pending;
	} out_item_t;

	// configuration registers
	typedef struct packed {
		logic        use_ctrl_word;
		logic        sequence_switch;
		logic [31:0] delay_to_ready;
		logic [31:0] delay_to_switched_on;
		logic [31:0] delay_to_enabled;
	} cfg_t;

	// narrow control state carried between ticks
	typedef struct packed {
		drv_state_t state;
		logic       delay_armed;
		logic       prev_reset_bit;
		logic       reset_request;
	} ctl_state_t;

	// command decode result
	typedef struct packed {
		cmd_t cmd;
		logic prev_reset_bit;
		logic reset_request;
	} dec_t;

	// status word bits for each state
	function automatic logic [15:0] state_bits(input drv_state_t st);
		logic [15:0] bits;
		bits = 16'h0000;
		unique case (st)
			ST_NOTREADY: bits = 16'h0000;
			ST_DISABLED: bits = 16'h0060;
			ST_READY:    bits = 16'h0021;
			ST_SWON:     bits = 16'h0023;
			ST_ENABLED:  bits = 16'h0027;
			ST_QSTOP:    bits = 16'h0007;
			ST_REACT:    bits = 16'h002F;
			ST_FAULT:    bits = 16'h0028;
			default:     bits = 16'h0000;
		endcase
		return bits;
	endfunction

endpackage

// ===== design/dpsm_cmd_dec.sv =====
// ----------------------------------------------------------------------------
// dpsm_cmd_dec
// Picks the command of a tick from the control word or the host field and, in
// control word mode, latches a fault reset request on a reset bit rising edge.
// ----------------------------------------------------------------------------
module dpsm_cmd_dec (
	input  logic [15:0]        ctrl_word,
	input  logic [2:0]         host_command,
	input  logic               use_ctrl_word,
	input  logic               prev_reset_bit,
	input  logic               reset_request,
	output dpsm_pkg::dec_t     dec
);
	import dpsm_pkg::*;

	logic rb;
	cmd_t cw_cmd;
	cmd_t host_cmd;

	// control word decode by priority
	always_comb begin
		if ((ctrl_word & CW_RESET_BIT) != 16'h0000) begin
			cw_cmd = CMD_RESET;
		end else if ((ctrl_word & CW_VOLTAGE) == 16'h0000) begin
			cw_cmd = CMD_DISV;
		end else if ((ctrl_word & CW_NO_QSTOP) == 16'h0000) begin
			cw_cmd = CMD_QSTOP;
		end else if ((ctrl_word & CW_SWITCH_ON) == 16'h0000) begin
			cw_cmd = CMD_SHUT;
		end else if ((ctrl_word & CW_CMD_MASK) == CW_CMD_ENABLE) begin
			cw_cmd = CMD_ENABLE;
		end else if ((ctrl_word & CW_CMD_MASK) == CW_CMD_SWON) begin
			cw_cmd = CMD_SWON;
		end else begin
			cw_cmd = CMD_NONE;
		end
	end

	// host command, unused code reads as none
	always_comb begin
		unique case (host_command)
			3'd0:    host_cmd = CMD_NONE;
			3'd1:    host_cmd = CMD_RESET;
			3'd2:    host_cmd = CMD_DISV;
			3'd3:    host_cmd = CMD_QSTOP;
			3'd4:    host_cmd = CMD_SHUT;
			3'd5:    host_cmd = CMD_ENABLE;
			3'd6:    host_cmd = CMD_SWON;
			default: host_cmd = CMD_NONE;
		endcase
	end

	assign rb = (ctrl_word & CW_RESET_BIT) != 16'h0000;

	// edge detect only runs in control word mode
	always_comb begin
		if (use_ctrl_word) begin
			dec.cmd            = cw_cmd;
			dec.prev_reset_bit = rb;
			dec.reset_request  = reset_request | (rb & ~prev_reset_bit);
		end else begin
			dec.cmd            = host_cmd;
			dec.prev_reset_bit = prev_reset_bit;
			dec.reset_request  = reset_request;
		end
	end

endmodule

// ===== design/dpsm_step.sv =====
// ----------------------------------------------------------------------------
// dpsm_step
// One pass of the power state machine: transitions, timed advances, fault
// entry and reset, plus the result beat of the tick.
// ----------------------------------------------------------------------------
module dpsm_step #(
	parameter int TICK_BITS = 32
) (
	input  dpsm_pkg::ctl_state_t    cur,
	input  logic [TICK_BITS-1:0]    start_tick,
	input  dpsm_pkg::dec_t          dec,
	input  dpsm_pkg::cfg_t          cfg,
	input  dpsm_pkg::in_item_t      item,
	output dpsm_pkg::ctl_state_t    nxt,
	output logic [TICK_BITS-1:0]    nxt_start_tick,
	output dpsm_pkg::out_item_t     result
);
	import dpsm_pkg::*;

	localparam int CMP_BITS = (TICK_BITS > 32) ? TICK_BITS : 32;

	logic [TICK_BITS-1:0] now;
	logic [TICK_BITS-1:0] base;
	logic [TICK_BITS-1:0] diff;
	logic [31:0]          delay;
	logic                 reached;
	logic                 is_err;
	logic                 is_next;
	cmd_t                 cmd;
	cmd_t                 cmd_out;
	drv_state_t           adv_to;
	logic                 adv_req;

	assign now     = TICK_BITS'(item.tick_now);
	assign cmd     = dec.cmd;
	assign is_err  = item.step_result == STEP_ERROR;
	assign is_next = item.step_result[1];

	// which timed advance this state may ask for
	always_comb begin
		delay   = cfg.delay_to_ready;
		adv_to  = ST_READY;
		adv_req = 1'b0;
		unique case (cur.state)
			ST_DISABLED: begin
				delay   = cfg.delay_to_ready;
				adv_to  = ST_READY;
				adv_req = (cmd == CMD_SHUT) ||
					(cfg.sequence_switch && (cmd == CMD_SWON || cmd == CMD_ENABLE));
			end
			ST_READY: begin
				delay   = cfg.delay_to_switched_on;
				adv_to  = ST_SWON;
				adv_req = (cmd == CMD_SWON) || (cfg.sequence_switch && cmd == CMD_ENABLE);
			end
			ST_SWON: begin
				delay   = cfg.delay_to_enabled;
				adv_to  = ST_ENABLED;
				adv_req = cmd == CMD_ENABLE;
			end
			default: begin
				delay   = cfg.delay_to_ready;
				adv_to  = ST_READY;
				adv_req = 1'b0;
			end
		endcase
	end

	// dwell distance, start taken on the first asking tick
	assign base    = cur.delay_armed ? start_tick : now;
	assign diff    = now - base;
	assign reached = CMP_BITS'(diff) >= CMP_BITS'(delay);

	// next state
	always_comb begin
		nxt            = cur;
		nxt.prev_reset_bit = dec.prev_reset_bit;
		nxt.reset_request  = dec.reset_request;
		nxt_start_tick = start_tick;
		cmd_out        = cmd;
		if (is_err && (cur.state == ST_DISABLED || cur.state == ST_READY ||
				cur.state == ST_SWON || cur.state == ST_ENABLED || cur.state == ST_QSTOP)) begin
			// fault entry, reaction may finish in the same tick
			nxt.reset_request = 1'b0;
			nxt.delay_armed   = 1'b0;
			nxt.state         = item.reaction_done ? ST_FAULT : ST_REACT;
		end else begin
			unique case (cur.state)
				ST_NOTREADY: begin
					nxt.state       = ST_DISABLED;
					nxt.delay_armed = 1'b0;
				end
				ST_DISABLED, ST_READY, ST_SWON: begin
					if (cur.state != ST_DISABLED && cmd == CMD_DISV) begin
						nxt.state       = ST_DISABLED;
						nxt.delay_armed = 1'b0;
					end else if (cur.state == ST_SWON && cmd == CMD_SHUT) begin
						nxt.state       = ST_READY;
						nxt.delay_armed = 1'b0;
					end else if (is_next) begin
						if (adv_req) begin
							nxt_start_tick = base;
							nxt.delay_armed = ~reached;
							if (reached) begin
								nxt.state = adv_to;
							end
						end
					end else begin
						nxt.delay_armed = 1'b0;
					end
				end
				ST_ENABLED: begin
					if (cmd == CMD_DISV) begin
						nxt.state       = ST_DISABLED;
						nxt.delay_armed = 1'b0;
					end else if (cmd == CMD_SHUT) begin
						nxt.state       = ST_READY;
						nxt.delay_armed = 1'b0;
					end else if (cmd == CMD_SWON) begin
						nxt.state       = ST_SWON;
						nxt.delay_armed = 1'b0;
					end else if (cmd == CMD_QSTOP) begin
						nxt.state       = ST_QSTOP;
						nxt.delay_armed = 1'b0;
					end
				end
				ST_QSTOP: begin
					if (is_next) begin
						nxt.state       = ST_DISABLED;
						nxt.delay_armed = 1'b0;
					end
				end
				ST_REACT: begin
					if (is_next) begin
						nxt.state       = ST_FAULT;
						nxt.delay_armed = 1'b0;
					end
				end
				ST_FAULT: begin
					// latched until a reset request is seen
					cmd_out = CMD_NONE;
					if (dec.reset_request) begin
						nxt.state         = ST_DISABLED;
						nxt.delay_armed   = 1'b0;
						nxt.reset_request = 1'b0;
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

	// result beat
	always_comb begin
		result.drive_state    = nxt.state;
		result.stat_word      = (item.status_extra & ~SW_STATE_MASK) | state_bits(nxt.state);
		result.active_command = cmd_out;
		result.reset_pending  = nxt.reset_request;
	end

endmodule

// ===== design/drive_power_state_machine_unit.sv =====
// ----------------------------------------------------------------------------
// drive_power_state_machine_unit
// Drive power state machine: one dispatch tick in, one status beat out.
// ----------------------------------------------------------------------------
// Each accepted tick produces exactly one result beat: the tick is captured in
// an input register, runs combinationally through the command decoder and the
// state step logic, and lands in the result register, which offers the beat.
// A new tick is taken every cycle while the result side keeps up; a stalled
// result beat holds the next tick in the input register and stalls the input.
// The single state register is read and updated once per tick, which keeps the
// rate at one tick per cycle. The configuration registers are written through
// the plain write port and should only change while no tick is in flight.
module drive_power_state_machine_unit #(
	parameter int TICK_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  dpsm_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output dpsm_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [dpsm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [dpsm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import dpsm_pkg::*;

	cfg_t                 cfg_q;
	ctl_state_t           ctl_q;
	logic [TICK_BITS-1:0] start_tick_q;
	logic                 valid_s1;
	in_item_t             item_s1;
	logic                 out_valid_q;
	out_item_t            out_data_q;

	dec_t                 dec;
	ctl_state_t           ctl_nxt;
	logic [TICK_BITS-1:0] start_tick_nxt;
	out_item_t            result;
	logic                 fire;
	logic                 accept;

	// handshake
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_ctrl_word        <= 1'b1;
			cfg_q.sequence_switch      <= 1'b0;
			cfg_q.delay_to_ready       <= '0;
			cfg_q.delay_to_switched_on <= '0;
			cfg_q.delay_to_enabled     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_USE_CW:    cfg_q.use_ctrl_word        <= cfg_data[0];
				CFG_SEQ_SW:    cfg_q.sequence_switch      <= cfg_data[0];
				CFG_DLY_READY: cfg_q.delay_to_ready       <= cfg_data;
				CFG_DLY_SWON:  cfg_q.delay_to_switched_on <= cfg_data;
				CFG_DLY_EN:    cfg_q.delay_to_enabled     <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// command decode
	dpsm_cmd_dec u_cmd_dec (
		.ctrl_word        (item_s1.ctrl_word),
		.host_command     (item_s1.host_command),
		.use_ctrl_word    (cfg_q.use_ctrl_word),
		.prev_reset_bit   (ctl_q.prev_reset_bit),
		.reset_request    (ctl_q.reset_request),
		.dec              (dec)
	);

	// state step
	dpsm_step #(
		.TICK_BITS (TICK_BITS)
	) u_step (
		.cur            (ctl_q),
		.start_tick     (start_tick_q),
		.dec            (dec),
		.cfg            (cfg_q),
		.item           (item_s1),
		.nxt            (ctl_nxt),
		.nxt_start_tick (start_tick_nxt),
		.result         (result)
	);

	// machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.state          <= ST_NOTREADY;
			ctl_q.delay_armed    <= 1'b0;
			ctl_q.prev_reset_bit <= 1'b0;
			ctl_q.reset_request  <= 1'b0;
			start_tick_q         <= '0;
		end else if (fire) begin
			ctl_q        <= ctl_nxt;
			start_tick_q <= start_tick_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= result;
		end
	end

	// checks
	a_fault_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctl_q.state == ST_FAULT) |=> out_data_q.active_command == CMD_NONE)
		else $error("fault tick reported a command");

	a_notready_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctl_q.state == ST_NOTREADY) |=> ctl_q.state == ST_DISABLED)
		else $error("not ready did not move to switch on disabled");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_data_q.drive_state == ctl_q.state)
		else $error("result beat disagrees with state register");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

endmodule

// ===== test/tb_drive_power_state_machine_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_drive_power_state_machine_unit
// Self-checking bench for the drive power state machine. A short table of
// dispatch ticks walks the power states, fault entry and fault reset. Several
// configuration phases of steered random ticks follow, with random gaps and
// result-side stalls. Every result beat is compared field by field with a
// local prediction of the state machine, or for checked rows with the table.
// ----------------------------------------------------------------------------
module tb_drive_power_state_machine_unit;
	import dpsm_pkg::*;

	// verdict three behaves like next
	localparam logic [1:0] STEP_NEXT_ALT = 2'd3;
	// register index that maps to no register
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 3'd7;

	typedef struct packed {
		in_item_t  beat;
		logic      chk;
		out_item_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// predicted drive state and configuration
	drv_state_t exp_state = ST_NOTREADY;
	logic dwell_armed = 1'b0;
	logic [31:0] dwell_start = '0;
	logic last_rst_bit = 1'b0;
	logic rst_latched = 1'b0;
	logic cw_mode = 1'b1;
	logic seq_mode = 1'b0;
	logic [31:0] dwell_ready = '0;
	logic [31:0] dwell_swon = '0;
	logic [31:0] dwell_enable = '0;

	out_item_t want_beats[$];
	dir_row_t dir_rows[$];
	logic [31:0] tick_run = '0;
	bit quiet = 1'b0;
	int stall_left = 0;
	int errors = 0;
	int beats_checked = 0;
	int ticks_sent = 0;
	int phases_run = 0;
	int faults_seen = 0;
	int fault_clears = 0;

	drive_power_state_machine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic void go_state(input drv_state_t nxt);
		exp_state = nxt;
		dwell_armed = 1'b0;
	endfunction

	// fault reaction runs once in the entering tick
	function automatic void fault_entry(input logic done);
		rst_latched = 1'b0;
		faults_seen++;
		go_state(ST_REACT);
		if (done)
			go_state(ST_FAULT);
	endfunction

	// arm on the first request, advance once the dwell has elapsed
	function automatic void dwell_advance(input logic [31:0] now, input logic [31:0] need,
			input drv_state_t nxt);
		logic [31:0] gap;
		if (!dwell_armed) begin
			dwell_start = now;
			dwell_armed = 1'b1;
		end
		gap = now - dwell_start;
		if (gap >= need)
			go_state(nxt);
	endfunction

	function automatic out_item_t next_status_beat(input in_item_t t);
		cmd_t c;
		logic rb;
		logic err;
		logic adv;
		logic [15:0] code;
		out_item_t o;
		err = (t.step_result == STEP_ERROR);
		adv = (t.step_result >= STEP_NEXT);
		// command source and fault reset edge
		if (cw_mode) begin
			rb = (t.ctrl_word & CW_RESET_BIT) != 0;
			if (rb)
				c = CMD_RESET;
			else if ((t.ctrl_word & CW_VOLTAGE) == 0)
				c = CMD_DISV;
			else if ((t.ctrl_word & CW_NO_QSTOP) == 0)
				c = CMD_QSTOP;
			else if ((t.ctrl_word & CW_SWITCH_ON) == 0)
				c = CMD_SHUT;
			else if ((t.ctrl_word & CW_CMD_MASK) == CW_CMD_ENABLE)
				c = CMD_ENABLE;
			else if ((t.ctrl_word & CW_CMD_MASK) == CW_CMD_SWON)
				c = CMD_SWON;
			else
				c = CMD_NONE;
			if (rb && !last_rst_bit)
				rst_latched = 1'b1;
			last_rst_bit = rb;
		end else if (t.host_command > CMD_SWON) begin
			c = CMD_NONE;
		end else begin
			c = cmd_t'(t.host_command);
		end
		// one step of the power state
		case (exp_state)
			ST_NOTREADY: go_state(ST_DISABLED);
			ST_DISABLED: begin
				if (err)
					fault_entry(t.reaction_done);
				else if (adv) begin
					if (c == CMD_SHUT || (seq_mode && (c == CMD_SWON || c == CMD_ENABLE)))
						dwell_advance(t.tick_now, dwell_ready, ST_READY);
				end else
					dwell_armed = 1'b0;
			end
			ST_READY: begin
				if (err)
					fault_entry(t.reaction_done);
				else if (c == CMD_DISV)
					go_state(ST_DISABLED);
				else if (adv) begin
					if (c == CMD_SWON || (seq_mode && c == CMD_ENABLE))
						dwell_advance(t.tick_now, dwell_swon, ST_SWON);
				end else
					dwell_armed = 1'b0;
			end
			ST_SWON: begin
				if (err)
					fault_entry(t.reaction_done);
				else if (c == CMD_DISV)
					go_state(ST_DISABLED);
				else if (c == CMD_SHUT)
					go_state(ST_READY);
				else if (adv) begin
					if (c == CMD_ENABLE)
						dwell_advance(t.tick_now, dwell_enable, ST_ENABLED);
				end else
					dwell_armed = 1'b0;
			end
			ST_ENABLED: begin
				if (err)
					fault_entry(t.reaction_done);
				else if (c == CMD_DISV)
					go_state(ST_DISABLED);
				else if (c == CMD_SHUT)
					go_state(ST_READY);
				else if (c == CMD_SWON)
					go_state(ST_SWON);
				else if (c == CMD_QSTOP)
					go_state(ST_QSTOP);
			end
			ST_QSTOP: begin
				if (err)
					fault_entry(t.reaction_done);
				else if (adv)
					go_state(ST_DISABLED);
			end
			ST_REACT: begin
				if (adv)
					go_state(ST_FAULT);
			end
			default: begin
				// latched fault: command suppressed, leaves only on a reset request
				c = CMD_NONE;
				if (rst_latched) begin
					go_state(ST_DISABLED);
					rst_latched = 1'b0;
					fault_clears++;
				end
			end
		endcase
		case (exp_state)
			ST_DISABLED: code = 16'h0060;
			ST_READY:    code = 16'h0021;
			ST_SWON:     code = 16'h0023;
			ST_ENABLED:  code = 16'h0027;
			ST_QSTOP:    code = 16'h0007;
			ST_REACT:    code = 16'h002F;
			ST_FAULT:    code = 16'h0028;
			default:     code = 16'h0000;
		endcase
		o.drive_state = exp_state;
		o.stat_word = (t.status_extra & ~SW_STATE_MASK) | code;
		o.active_command = c;
		o.reset_pending = rst_latched;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	// random control word that decodes to the given command
	function automatic logic [15:0] word_for(input cmd_t c);
		logic [15:0] w;
		w = 16'($urandom) & ~CW_RESET_BIT;
		case (c)
			CMD_RESET:  w = w | CW_RESET_BIT;
			CMD_DISV:   w = w & ~CW_VOLTAGE;
			CMD_QSTOP:  w = (w | CW_VOLTAGE) & ~CW_NO_QSTOP;
			CMD_SHUT:   w = (w | CW_VOLTAGE | CW_NO_QSTOP) & ~CW_SWITCH_ON;
			CMD_SWON:   w = (w & ~CW_CMD_MASK) | CW_CMD_SWON;
			CMD_ENABLE: w = (w & ~CW_CMD_MASK) | CW_CMD_ENABLE;
			default:    w = 16'($urandom);
		endcase
		return w;
	endfunction

	// command that moves the predicted state forward
	function automatic cmd_t steer_cmd();
		case (exp_state)
			ST_DISABLED: begin
				if (seq_mode && $urandom_range(0, 1) == 1)
					return ($urandom_range(0, 1) == 1) ? CMD_SWON : CMD_ENABLE;
				return CMD_SHUT;
			end
			ST_READY: begin
				if (seq_mode && $urandom_range(0, 1) == 1)
					return CMD_ENABLE;
				return CMD_SWON;
			end
			ST_SWON:    return CMD_ENABLE;
			ST_ENABLED: return cmd_t'($urandom_range(int'(CMD_DISV), int'(CMD_SWON)));
			ST_FAULT:   return CMD_RESET;
			default:    return cmd_t'($urandom_range(int'(CMD_RESET), int'(CMD_SWON)));
		endcase
	endfunction

	task automatic make_tick(output in_item_t t);
		cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			c = steer_cmd();
		else
			c = cmd_t'($urandom_range(int'(CMD_RESET), int'(CMD_SWON)));
		if (pick >= 92) begin
			// noise on both command sources
			t.ctrl_word = 16'($urandom);
			t.host_command = 3'($urandom);
		end else begin
			t.ctrl_word = word_for(c);
			t.host_command = c;
		end
		pick = $urandom_range(0, 99);
		if (pick < (cw_mode ? 4 : 1))
			t.step_result = STEP_ERROR;
		else if (pick < 28)
			t.step_result = STEP_KEEP;
		else
			t.step_result = ($urandom_range(0, 3) == 0) ? STEP_NEXT_ALT : STEP_NEXT;
		t.reaction_done = 1'($urandom);
		// tick time: mostly slow progress, sometimes a jump or the largest distance
		pick = $urandom_range(0, 99);
		if (pick < 3)
			tick_run = $urandom;
		else if (pick < 10 && dwell_armed)
			tick_run = dwell_start - 32'd1;
		else
			tick_run = tick_run + 32'($urandom_range(0, 2));
		t.tick_now = tick_run;
		t.status_extra = 16'($urandom);
	endtask

	task automatic add_row(input logic [15:0] cw, input logic [1:0] verdict, input logic done,
			input logic [31:0] tk, input logic [15:0] extra, input logic chk,
			input out_item_t want);
		dir_row_t r;
		r.beat.ctrl_word = cw;
		r.beat.host_command = 3'(dir_rows.size());
		r.beat.step_result = verdict;
		r.beat.reaction_done = done;
		r.beat.tick_now = tk;
		r.beat.status_extra = extra;
		r.chk = chk;
		r.want = want;
		dir_rows.push_back(r);
	endtask

	// one input beat, with an optional random gap in front
	task automatic send_tick(input in_item_t t, input logic chk, input out_item_t want);
		out_item_t guess;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_data <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		guess = next_status_beat(t);
		want_beats.push_back(chk ? want : guess);
		ticks_sent++;
	endtask

	// hold off until every result beat is back
	task automatic drain_all();
		in_valid <= 1'b0;
		do @(posedge clk); while (want_beats.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_USE_CW:    cw_mode = data[0];
			CFG_SEQ_SW:    seq_mode = data[0];
			CFG_DLY_READY: dwell_ready = data;
			CFG_DLY_SWON:  dwell_swon = data;
			CFG_DLY_EN:    dwell_enable = data;
			default: ;
		endcase
	endtask

	task automatic run_phase(input logic [31:0] mode_word, input logic [31:0] seq_word,
			input logic [31:0] d_ready, input logic [31:0] d_swon, input logic [31:0] d_en,
			input int n, input bit last);
		in_item_t beat;
		drain_all();
		write_reg(CFG_USE_CW, mode_word);
		write_reg(CFG_SEQ_SW, seq_word);
		write_reg(CFG_DLY_READY, d_ready);
		write_reg(CFG_DLY_SWON, d_swon);
		write_reg(CFG_DLY_EN, d_en);
		write_reg(CFG_IDX_UNUSED, $urandom);
		cfg_we <= 1'b0;
		quiet = last;
		phases_run++;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				drain_all();
			make_tick(beat);
			send_tick(beat, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// result check and result-side stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (want_beats.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected: %h", $time, out_data);
			end else begin
				want = want_beats.pop_front();
				beats_checked++;
				if (out_data.drive_state !== want.drive_state) begin
					errors++;
					$display("%0t: drive_state expected %0d, got %0d", $time,
						want.drive_state, out_data.drive_state);
				end
				if (out_data.stat_word !== want.stat_word) begin
					errors++;
					$display("%0t: stat_word expected %h, got %h", $time,
						want.stat_word, out_data.stat_word);
				end
				if (out_data.active_command !== want.active_command) begin
					errors++;
					$display("%0t: active_command expected %0d, got %0d", $time,
						want.active_command, out_data.active_command);
				end
				if (out_data.reset_pending !== want.reset_pending) begin
					errors++;
					$display("%0t: reset_pending expected %b, got %b", $time,
						want.reset_pending, out_data.reset_pending);
				end
			end
		end
		// random result-side stall bursts, none in the quiet last phase
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk through the power states with default configuration
		add_row(16'h0000, STEP_KEEP, 1'b0, 32'd1, 16'hFFFF, 1'b1,
			out_item_t'{ST_DISABLED, 16'hFFF0, CMD_DISV, 1'b0});
		add_row(16'h0006, STEP_NEXT, 1'b0, 32'd2, 16'h0000, 1'b1,
			out_item_t'{ST_READY, 16'h0021, CMD_SHUT, 1'b0});
		add_row(16'h0007, STEP_NEXT, 1'b0, 32'd3, 16'($urandom), 1'b0, '0);
		add_row(16'h000F, STEP_NEXT, 1'b1, 32'd4, 16'($urandom), 1'b0, '0);
		add_row(16'h000B, STEP_NEXT, 1'b0, 32'd5, 16'($urandom), 1'b0, '0);
		add_row(16'h000B, STEP_KEEP, 1'b0, 32'd6, 16'($urandom), 1'b0, '0);
		add_row(16'h000B, STEP_NEXT, 1'b0, 32'd7, 16'($urandom), 1'b0, '0);
		// error verdict enters fault reaction, which then waits for next
		add_row(16'h0006, STEP_ERROR, 1'b0, 32'd8, 16'h1234, 1'b1,
			out_item_t'{ST_REACT, 16'h123F, CMD_SHUT, 1'b0});
		add_row(16'h0006, STEP_KEEP, 1'b0, 32'd9, 16'($urandom), 1'b0, '0);
		add_row(16'h0006, STEP_NEXT_ALT, 1'b0, 32'd10, 16'($urandom), 1'b0, '0);
		// fault reset edge clears the fault
		add_row(16'h0080, STEP_KEEP, 1'b0, 32'd11, 16'($urandom), 1'b0, '0);
		add_row(16'h0080, STEP_KEEP, 1'b0, 32'd12, 16'($urandom), 1'b0, '0);
		add_row(16'h0000, STEP_KEEP, 1'b0, 32'd13, 16'($urandom), 1'b0, '0);
		add_row(16'h0080, STEP_KEEP, 1'b0, 32'd14, 16'h0000, 1'b1,
			out_item_t'{ST_DISABLED, 16'h0060, CMD_RESET, 1'b1});
		// reaction done in the same tick goes straight to fault, request dropped
		add_row(16'h0006, STEP_ERROR, 1'b1, 32'd15, 16'h0000, 1'b1,
			out_item_t'{ST_FAULT, 16'h0028, CMD_SHUT, 1'b0});
		add_row(16'h0006, STEP_NEXT, 1'b0, 32'd16, 16'($urandom), 1'b0, '0);
		add_row(16'h0080, STEP_KEEP, 1'b0, 32'd17, 16'($urandom), 1'b0, '0);
		// quick stop ignored in ready and switched on
		add_row(16'h0006, STEP_NEXT, 1'b0, 32'd18, 16'($urandom), 1'b0, '0);
		add_row(16'h000B, STEP_NEXT, 1'b0, 32'd19, 16'($urandom), 1'b0, '0);
		add_row(16'h0007, STEP_NEXT, 1'b0, 32'd20, 16'($urandom), 1'b0, '0);
		add_row(16'h000B, STEP_NEXT, 1'b0, 32'd21, 16'($urandom), 1'b0, '0);
		// extremes of the control word and status bits
		add_row(16'hFF7F, STEP_NEXT, 1'b0, 32'd22, 16'hFFFF, 1'b1,
			out_item_t'{ST_ENABLED, 16'hFFB7, CMD_ENABLE, 1'b0});
		add_row(16'hFF7D, STEP_NEXT, 1'b0, 32'd23, 16'($urandom), 1'b0, '0);
		add_row(16'hFFFF, STEP_ERROR, 1'b1, 32'd24, 16'hFFFF, 1'b1,
			out_item_t'{ST_FAULT, 16'hFFB8, CMD_RESET, 1'b0});
		add_row(16'h0000, STEP_KEEP, 1'b0, 32'hFFFF_FFFF, 16'h0000, 1'b1,
			out_item_t'{ST_FAULT, 16'h0028, CMD_NONE, 1'b0});

		foreach (dir_rows[i])
			send_tick(dir_rows[i].beat, dir_rows[i].chk, dir_rows[i].want);
		tick_run = 32'hFFFF_FFFF;

		// random phases over several configurations
		run_phase(32'h1, 32'h1, 32'd2, 32'd1, 32'd3, 105, 1'b0);
		run_phase(32'hFFFF_FFFE, 32'h0, 32'd0, 32'd0, 32'd0, 105, 1'b0);
		run_phase(32'h0, 32'h1, 32'd1, 32'd2, 32'd0, 105, 1'b0);
		run_phase(32'h1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 105, 1'b0);
		run_phase(32'h1, 32'h1, 32'($urandom_range(0, 4)), 32'($urandom_range(0, 4)),
			32'($urandom_range(0, 4)), 105, 1'b0);
		run_phase(32'h1, 32'h0, 32'd0, 32'd0, 32'd0, 105, 1'b1);
		drain_all();

		$display("covered %0d ticks over %0d random configuration phases, both command sources",
			ticks_sent, phases_run);
		$display("%0d fault entries, %0d resets out of fault, %0d result beats checked",
			faults_seen, fault_clears, beats_checked);
		if (errors == 0 && want_beats.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
